/* sv/kct_pkg.sv */
// Package for the keyword counter tokenizer: sizes, operation codes and the
// request/result structs shared by the tokenizer, search unit and top level.
// No dependencies.
package kct_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int WORD_LIMIT  = 100;
  localparam int KEY_CHARS   = 8;

  localparam int KEY_W   = 64;
  localparam int CHAR_W  = 8;
  localparam int OP_W    = 2;
  localparam int FIDX_W  = 5;   // entry_index / hit_index field width
  localparam int COUNT_W = 16;
  localparam int ECNT_W  = 6;   // entry_count register width

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W = $clog2(WORD_LIMIT);

  localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;
  localparam logic [OP_W-1:0] OP_EOS  = 2'd3;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SEARCH,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             overlong;
  } word_end_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [FIDX_W-1:0] index;
    logic [KEY_W-1:0]  key;
    logic              overlong;
  } search_req_t;

  typedef struct packed {
    logic               kind;
    logic               hit;
    logic [FIDX_W-1:0]  hit_index;
    logic [COUNT_W-1:0] count_value;
  } result_t;

endpackage

/* sv/kct_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on kct_pkg.
interface kct_in_if;
  logic                          valid;
  logic                          ready;
  logic [kct_pkg::OP_W-1:0]      op;
  logic [kct_pkg::CHAR_W-1:0]    ch;
  logic [kct_pkg::FIDX_W-1:0]    entry_index;
  logic [kct_pkg::KEY_W-1:0]     entry_key;

  modport source (output valid, op, ch, entry_index, entry_key, input ready);
  modport sink   (input valid, op, ch, entry_index, entry_key, output ready);
endinterface

interface kct_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          hit;
  logic [kct_pkg::FIDX_W-1:0]    hit_index;
  logic [kct_pkg::COUNT_W-1:0]   count_value;

  modport source (output valid, kind, hit, hit_index, count_value, input ready);
  modport sink   (input valid, kind, hit, hit_index, count_value, output ready);
endinterface

/* sv/kct_tokenizer.sv */
// Word assembler: classifies characters, packs the word big-endian and flags
// the end of a word. Depends on kct_pkg.
module kct_tokenizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       flush,
  input  logic [kct_pkg::CHAR_W-1:0] ch,
  output kct_pkg::word_end_t         word_end
);
  import kct_pkg::*;

  logic [KEY_W-1:0] word_key;
  logic [LEN_W-1:0] word_length;
  logic             word_overlong;

  logic [KEY_W-1:0] key_app;
  logic             ovl_app;
  logic [LEN_W:0]   len_app;
  logic             is_letter;
  logic             is_digit;
  logic             do_append;
  logic             end_now;
  logic             end_limit;

  always_comb begin
    is_letter = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    is_digit  = (ch inside {[8'h30:8'h39]});

    key_app = word_key;
    for (int b = 0; b < 8; b++) begin
      if (int'(word_length) == b && b < KEY_CHARS) begin
        key_app[KEY_W-1-8*b -: 8] = ch;
      end
    end
    ovl_app = word_overlong || (int'(word_length) >= KEY_CHARS);
    len_app = {1'b0, word_length} + 1'b1;

    do_append = 1'b0;
    end_now   = 1'b0;
    if (step) begin
      if (word_length == '0) begin
        do_append = is_letter;
      end else if (is_letter || is_digit) begin
        do_append = 1'b1;
      end else begin
        end_now = 1'b1;
      end
    end else if (flush) begin
      end_now = (word_length != '0);
    end
    end_limit = do_append && (int'(len_app) >= WORD_LIMIT - 1);

    word_end.valid    = end_now || end_limit;
    word_end.key      = end_limit ? key_app : word_key;
    word_end.overlong = end_limit ? ovl_app : word_overlong;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_key      <= '0;
      word_length   <= '0;
      word_overlong <= 1'b0;
    end else if (word_end.valid) begin
      word_key      <= '0;
      word_length   <= '0;
      word_overlong <= 1'b0;
    end else if (do_append) begin
      word_key      <= key_app;
      word_length   <= len_app[LEN_W-1:0];
      word_overlong <= ovl_app;
    end
  end

endmodule

/* sv/kct_search.sv */
// Keyword table, count table and the sequencer that runs the binary search
// one probe at a time through a single compare unit. Depends on kct_pkg.
module kct_search (
  input  logic                       clk,
  input  logic                       rst,
  input  kct_pkg::search_req_t       req,
  input  logic [kct_pkg::ECNT_W-1:0] entry_count,
  output logic                       idle,
  output logic                       res_valid,
  input  logic                       res_take,
  output kct_pkg::result_t           res
);
  import kct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_CNT_RD,
    S_CNT_WR,
    S_DONE
  } state_t;

  state_t state;

  logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0] cnt_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cnt_vld;

  logic [KEY_W-1:0]   wkey;
  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               vld_q;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;    // exclusive upper bound
  logic [IDX_W-1:0]   mid_q;
  logic [IDX_W-1:0]   addr;

  logic [CNT_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid;
  logic [CNT_W-1:0]   n_used;
  logic [IDX_W-1:0]   req_addr;
  logic               req_in_range;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] cnt_inc;
  logic               load_wr;
  logic               cnt_wr;

  always_comb begin
    mid_sum      = {1'b0, lo} + {1'b0, hi} - 1'b1;
    mid          = mid_sum[IDX_W:1];
    n_used       = (int'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(entry_count);
    req_addr     = IDX_W'(req.index);
    req_in_range = (int'(req.index) < TABLE_DEPTH);
    cur          = vld_q ? cnt_q : '0;
    cnt_inc      = (cur == '1) ? cur : cur + 1'b1;
    load_wr      = (state == S_IDLE) && (req.cmd == CMD_LOAD) && req_in_range;
    cnt_wr       = (state == S_CNT_WR) && (res.kind == KIND_WORD);
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // keyword table: written by loads, read at the probe address
  always_ff @(posedge clk) begin
    if (load_wr) begin
      key_mem[req_addr] <= req.key;
    end
    key_q <= key_mem[mid];
  end

  // count table; a cleared valid bit makes the entry read as zero
  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[addr] <= cnt_inc;
    end
    cnt_q <= cnt_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt_vld <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          case (req.cmd)
            CMD_LOAD: begin
              if (req_in_range) begin
                cnt_vld[req_addr] <= 1'b0;
              end
            end
            CMD_SEARCH: begin
              wkey     <= req.key;
              lo       <= '0;
              hi       <= req.overlong ? '0 : n_used;
              res.kind <= KIND_WORD;
              state    <= S_PROBE;
            end
            CMD_READ: begin
              res.kind      <= KIND_READ;
              res.hit       <= 1'b0;
              res.hit_index <= req.index;
              addr          <= req_addr;
              if (req_in_range) begin
                state <= S_CNT_RD;
              end else begin
                res.count_value <= '0;
                state           <= S_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            res.hit         <= 1'b0;
            res.hit_index   <= '0;
            res.count_value <= '0;
            state           <= S_DONE;
          end
        end
        S_CMP: begin
          if (wkey < key_q) begin
            hi    <= CNT_W'(mid_q);
            state <= S_PROBE;
          end else if (wkey > key_q) begin
            lo    <= CNT_W'(mid_q) + 1'b1;
            state <= S_PROBE;
          end else begin
            addr  <= mid_q;
            state <= S_CNT_RD;
          end
        end
        S_CNT_RD: begin
          vld_q <= cnt_vld[addr];
          state <= S_CNT_WR;
        end
        S_CNT_WR: begin
          if (res.kind == KIND_READ) begin
            res.count_value <= cur;
          end else begin
            cnt_vld[addr]   <= 1'b1;
            res.hit         <= 1'b1;
            res.hit_index   <= FIDX_W'(addr);
            res.count_value <= cnt_inc;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/keyword_counter_tokenizer_core.sv */
// Channel        | Dir | Payload
// req            | in  | op, ch, entry_index, entry_key
// rsp            | out | kind, hit, hit_index, count_value
// cfg_write_*    | in  | entry_count (write only)
//
// A plain character, a load, or an end of stream with no word leaves the
// search unit idle; a count read steps through count read, write, hand-off.
// A word end: key read and compare per probe (up to 6 probes at depth 32),
// then count read, write, hand-off on a hit; range check, hand-off on a miss.
// Reset is synchronous; count valid bits clear at once, no clearing pass.
// Input stalls while the search unit is busy, including while it holds a result for a full output register.
module keyword_counter_tokenizer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [kct_pkg::ECNT_W-1:0] cfg_write_data,
  kct_in_if.sink                     req,
  kct_out_if.source                  rsp
);
  import kct_pkg::*;

  logic [ECNT_W-1:0] entry_count;
  logic              accept;
  logic              unit_idle;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  word_end_t         word_end;
  search_req_t       sreq;

  assign req.ready = unit_idle;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write_en) begin
      entry_count <= cfg_write_data;
    end
  end

  kct_tokenizer u_tok (
    .clk      (clk),
    .rst      (rst),
    .step     (accept && (req.op == OP_CHAR)),
    .flush    (accept && (req.op == OP_EOS)),
    .ch       (req.ch),
    .word_end (word_end)
  );

  always_comb begin
    sreq.index    = req.entry_index;
    sreq.key      = word_end.valid ? word_end.key : req.entry_key;
    sreq.overlong = word_end.overlong;
    sreq.cmd      = CMD_NONE;
    if (accept) begin
      case (req.op)
        OP_LOAD: sreq.cmd = CMD_LOAD;
        OP_READ: sreq.cmd = CMD_READ;
        default: sreq.cmd = word_end.valid ? CMD_SEARCH : CMD_NONE;
      endcase
    end
  end

  kct_search u_search (
    .clk         (clk),
    .rst         (rst),
    .req         (sreq),
    .entry_count (entry_count),
    .idle        (unit_idle),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  // output register: loads when empty or emptied by a transfer this cycle
  assign res_take = res_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp.kind        <= res.kind;
      rsp.hit         <= res.hit;
      rsp.hit_index   <= res.hit_index;
      rsp.count_value <= res.count_value;
    end
  end

endmodule
